[rtl/core/lnc_pkg.sv]
// Shared types, codes and frame-building functions of the node settings download sequencer.
`timescale 1ns / 1ps

package lnc_pkg;

    localparam int unsigned RETRY_LIMIT_DEF = 3;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned STEP_W = 3;
    localparam int unsigned IDX_W  = 5;

    // Event kinds.
    localparam logic [1:0] KIND_RX    = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    // Command steps.
    localparam logic [STEP_W-1:0] STEP_PWM       = 3'd0;
    localparam logic [STEP_W-1:0] STEP_LEVEL     = 3'd1;
    localparam logic [STEP_W-1:0] STEP_BRIGHT    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_TRIGGER   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_CHAN      = 3'd4;
    localparam logic [STEP_W-1:0] STEP_SWITCH    = 3'd5;
    localparam logic [STEP_W-1:0] STEP_DEV_RESET = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NODE_ID      = 3'd0;
    localparam logic [2:0] CFG_PWM          = 3'd1;
    localparam logic [2:0] CFG_LEVEL        = 3'd2;
    localparam logic [2:0] CFG_BRIGHT_MODE  = 3'd3;
    localparam logic [2:0] CFG_TRIGGER_MODE = 3'd4;
    localparam logic [2:0] CFG_CHAN_BRIGHT  = 3'd5;
    localparam logic [2:0] CFG_SWITCHES     = 3'd6;

    // Frame bytes and command codes.
    localparam logic [7:0] HDR_BYTE        = 8'h40;
    localparam logic [7:0] ADDR_TAG        = 8'h01;
    localparam logic [7:0] CMD_PWM         = 8'h11;
    localparam logic [7:0] CMD_LEVEL       = 8'h10;
    localparam logic [7:0] CMD_BRIGHT      = 8'h3A;
    localparam logic [7:0] CMD_TRIG_RESET  = 8'h33;
    localparam logic [7:0] CMD_TRIG        = 8'h32;
    localparam logic [7:0] CMD_CHAN_BRIGHT = 8'h1A;
    localparam logic [7:0] CMD_SWITCH      = 8'h2A;
    localparam logic [7:0] CMD_DEV_RESET   = 8'h23;
    localparam logic [7:0] TRIG_MODE_RESET = 8'd4;

    localparam logic [IDX_W-1:0] SIZE_SHORT  = 5'd7;
    localparam logic [IDX_W-1:0] SIZE_CHAN   = 5'd21;
    localparam logic [IDX_W-1:0] SIZE_SWITCH = 5'd14;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } evt_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
    } beat_t;

    typedef struct packed {
        logic [7:0]  node_id;
        logic [7:0]  pwm_value;
        logic [7:0]  level_value;
        logic [7:0]  bright_mode;
        logic [7:0]  trigger_mode;
        logic [63:0] channel_brightness;
        logic [23:0] switch_states;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [STEP_W-1:0] step;
    } frame_req_t;

    function automatic logic [IDX_W-1:0] frame_size(input logic [STEP_W-1:0] step);
        logic [IDX_W-1:0] n;
        if (step == STEP_CHAN) begin
            n = SIZE_CHAN;
        end else if (step == STEP_SWITCH) begin
            n = SIZE_SWITCH;
        end else begin
            n = SIZE_SHORT;
        end
        return n;
    endfunction

    // Byte idx of the frame for a step; the checksum byte is added by the caller.
    function automatic logic [7:0] frame_byte(input logic [STEP_W-1:0] step,
                                              input logic [IDX_W-1:0]  idx,
                                              input cfg_t              cfg);
        logic [7:0]       b;
        logic [IDX_W-1:0] k;
        logic [1:0]       grp;
        logic [15:0]      chv;
        k   = idx - IDX_W'(4);
        grp = k[3:2];
        chv = cfg.channel_brightness[{grp, 4'b0000} +: 16];
        b   = 8'h00;
        unique case (idx)
            5'd0: b = HDR_BYTE;
            5'd1: b = {3'b000, frame_size(step)} - 8'd3;
            5'd2: b = ADDR_TAG;
            5'd3: b = cfg.node_id;
            default:
            begin
                unique case (step)
                    STEP_PWM:     b = (idx == 5'd4) ? CMD_PWM : cfg.pwm_value;
                    STEP_LEVEL:   b = (idx == 5'd4) ? CMD_LEVEL : cfg.level_value;
                    STEP_BRIGHT:  b = (idx == 5'd4) ? CMD_BRIGHT : cfg.bright_mode;
                    STEP_TRIGGER:
                    begin
                        if (cfg.trigger_mode == TRIG_MODE_RESET) begin
                            b = (idx == 5'd4) ? CMD_TRIG_RESET : 8'h00;
                        end else begin
                            b = (idx == 5'd4) ? CMD_TRIG : cfg.trigger_mode;
                        end
                    end
                    STEP_CHAN:
                    begin
                        unique case (k[1:0])
                            2'd0: b = CMD_CHAN_BRIGHT;
                            2'd1: b = {6'b000000, grp};
                            2'd2: b = chv[7:0];
                            2'd3: b = chv[15:8];
                        endcase
                    end
                    STEP_SWITCH:
                    begin
                        unique case (idx)
                            5'd4, 5'd7, 5'd10: b = CMD_SWITCH;
                            5'd5:  b = 8'd0;
                            5'd8:  b = 8'd1;
                            5'd11: b = 8'd2;
                            5'd6:  b = cfg.switch_states[7:0];
                            5'd9:  b = cfg.switch_states[15:8];
                            5'd12: b = cfg.switch_states[23:16];
                            default: b = 8'h00;
                        endcase
                    end
                    STEP_DEV_RESET: b = (idx == 5'd4) ? CMD_DEV_RESET : 8'h00;
                    default:        b = 8'h00;
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

[rtl/core/lnc_front.sv]
// Front end: reply parser and command step sequencer that issues frame requests.
`timescale 1ns / 1ps

module lnc_front
    import lnc_pkg::*;
#(
    parameter int unsigned RETRY_LIMIT = RETRY_LIMIT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  evt_t       evt,
    output frame_req_t req
);

    localparam int unsigned RETRY_W = $clog2(RETRY_LIMIT + 1);

    localparam logic [1:0] PH_HDR  = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [1:0]         phase_reg, phase_next;
    logic [8:0]         idx_reg, idx_next;
    logic [7:0]         len_reg, len_next;
    logic [7:0]         status_reg, status_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [RETRY_W-1:0] retry_reg, retry_next;
    logic [RETRY_W-1:0] retry_inc;
    logic               reply_done;
    logic               advance;

    assign retry_inc = retry_reg + RETRY_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        status_next = status_reg;
        step_next   = step_reg;
        retry_next  = retry_reg;
        req         = '0;
        reply_done  = 1'b0;
        advance     = 1'b0;

        if (accept) begin
            unique case (evt.kind)
                KIND_START:
                begin
                    step_next = STEP_PWM;
                    req       = '{valid: 1'b1, step: STEP_PWM};
                end
                KIND_RESET:
                begin
                    step_next = STEP_DEV_RESET;
                    req       = '{valid: 1'b1, step: STEP_DEV_RESET};
                end
                KIND_RX:
                begin
                    unique case (phase_reg)
                        PH_HDR:
                        begin
                            if (evt.rx_byte == HDR_BYTE && idx_reg == 9'd0) begin
                                phase_next = PH_LEN;
                                idx_next   = 9'd1;
                            end else begin
                                phase_next = PH_HDR;
                                idx_next   = 9'd0;
                                len_next   = 8'd0;
                            end
                        end
                        PH_LEN:
                        begin
                            if (idx_reg == 9'd1) begin
                                len_next   = evt.rx_byte;
                                phase_next = PH_BODY;
                            end
                            if (idx_reg != 9'h1FF) begin
                                idx_next = idx_reg + 9'd1;
                            end
                        end
                        PH_BODY:
                        begin
                            if (idx_reg == 9'd4) begin
                                status_next = evt.rx_byte;
                            end
                            if (idx_reg >= {1'b0, len_reg} + 9'd2) begin
                                phase_next = PH_HDR;
                                idx_next   = 9'd0;
                                len_next   = 8'd0;
                                reply_done = 1'b1;
                            end else if (idx_reg != 9'h1FF) begin
                                idx_next = idx_reg + 9'd1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HDR;
                            idx_next   = 9'd0;
                            len_next   = 8'd0;
                        end
                    endcase
                end
                default: ;
            endcase
        end

        // A finished reply either retries the current step or moves on.
        if (reply_done) begin
            if (status_next == 8'd0) begin
                advance = 1'b1;
            end else if (retry_inc < RETRY_W'(RETRY_LIMIT)) begin
                retry_next = retry_inc;
                req        = '{valid: 1'b1, step: step_reg};
            end else begin
                advance = 1'b1;
            end
        end

        if (advance) begin
            retry_next = '0;
            if (step_reg < STEP_SWITCH) begin
                step_next = step_reg + STEP_W'(1);
                req       = '{valid: 1'b1, step: step_reg + STEP_W'(1)};
            end else begin
                step_next = STEP_DEV_RESET;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_HDR;
            idx_reg    <= '0;
            len_reg    <= '0;
            status_reg <= '0;
            step_reg   <= STEP_PWM;
            retry_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            status_reg <= status_next;
            step_reg   <= step_next;
            retry_reg  <= retry_next;
        end
    end

endmodule

[rtl/core/lnc_cmd_fifo.sv]
// Short queue of frame requests between the front end and the frame generator.
`timescale 1ns / 1ps

module lnc_cmd_fifo
    import lnc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [STEP_W-1:0] wr_step,
    input  logic              rd_en,
    output logic [STEP_W-1:0] rd_step,
    output logic              empty,
    output logic              full
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [STEP_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_step = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_step;
        end
    end

endmodule

[rtl/core/lnc_back.sv]
// Back end: turns frame requests into frame bytes with a running checksum.
`timescale 1ns / 1ps

module lnc_back
    import lnc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_empty,
    input  logic [STEP_W-1:0] q_step,
    output logic              q_rd,
    input  logic              pop,
    output logic              empty,
    output beat_t             beat
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]        sum_reg, sum_next;
    logic              out_valid_reg, out_valid_next;
    beat_t             out_reg, out_next;

    logic              slot_free;
    logic              go;
    logic [STEP_W-1:0] cur_step;
    logic [IDX_W-1:0]  cur_idx;
    logic [7:0]        cur_sum;
    logic              last;
    logic [7:0]        cur_byte;

    assign slot_free = !out_valid_reg || pop;
    assign go        = slot_free && (busy_reg || !q_empty);
    assign cur_step  = busy_reg ? step_reg : q_step;
    assign cur_idx   = busy_reg ? idx_reg : '0;
    assign cur_sum   = busy_reg ? sum_reg : 8'h00;
    assign last      = (cur_idx == frame_size(cur_step) - IDX_W'(1));
    assign cur_byte  = last ? cur_sum : frame_byte(cur_step, cur_idx, cfg);
    assign q_rd      = go && !busy_reg;
    assign empty     = !out_valid_reg;
    assign beat      = out_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        if (go) begin
            busy_next      = !last;
            step_next      = cur_step;
            idx_next       = cur_idx + IDX_W'(1);
            sum_next       = cur_sum + cur_byte;
            out_valid_next = 1'b1;
            out_next       = '{tx_byte: cur_byte, frame_end: last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        out_reg  <= out_next;
    end

endmodule

[rtl/core/light_node_config_download_sequencer.sv]
// Top level of the node settings download sequencer: config registers, front, queue, back.
// Usage: events enter as a queue write (push/full, payload evt). A start event requests
// the settings frame of step 0, a reset event the device-reset frame, and received
// bytes are parsed into reply frames whose status byte and retry count decide whether
// the current frame is resent or the next step's frame, if any, is requested.
// Frame bytes leave as a queue read (empty/pop, payload frame_beat); frame_end marks
// the checksum beat, the last of each frame.
// A beat that requests a frame is written into the request queue when it is accepted;
// the generator then takes the request and loads the first frame beat into the output
// register, from which it can be taken; a busy generator or a stalled output delays this.
// Throughput: the event side takes one beat per cycle while the request queue has
// room; the frame generator emits one beat per cycle while the receiver pops, and a
// frame is 7, 14 or 21 beats long, so the generator sets the sustained rate.
// When the receiver stalls, the output register holds its beat, the generator waits,
// the request queue fills and full rises; events that request no frame still pass
// as long as full is low.
// Reset clears the parser, step, retry count, queue and output; the configuration
// registers reset to zero and are written through cfg_wr_en/cfg_index/cfg_value.
// The user must write them only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

module light_node_config_download_sequencer
    import lnc_pkg::*;
#(
    parameter int unsigned RETRY_LIMIT = RETRY_LIMIT_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  evt_t        evt,
    input  logic        pop,
    output logic        empty,
    output beat_t       frame_beat,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_value
);

    cfg_t              cfg_reg, cfg_next;
    logic              accept;
    frame_req_t        req;
    logic              q_rd;
    logic              q_empty;
    logic [STEP_W-1:0] q_step;

    // Configuration registers; indexes beyond the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NODE_ID:      cfg_next.node_id            = cfg_value[7:0];
                CFG_PWM:          cfg_next.pwm_value          = cfg_value[7:0];
                CFG_LEVEL:        cfg_next.level_value        = cfg_value[7:0];
                CFG_BRIGHT_MODE:  cfg_next.bright_mode        = cfg_value[7:0];
                CFG_TRIGGER_MODE: cfg_next.trigger_mode       = cfg_value[7:0];
                CFG_CHAN_BRIGHT:  cfg_next.channel_brightness = cfg_value;
                CFG_SWITCHES:     cfg_next.switch_states      = cfg_value[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // An event beat is taken whenever the request queue has room.
    assign accept = push && !full;

    lnc_front #(
        .RETRY_LIMIT (RETRY_LIMIT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .evt    (evt),
        .req    (req)
    );

    lnc_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (req.valid),
        .wr_step (req.step),
        .rd_en   (q_rd),
        .rd_step (q_step),
        .empty   (q_empty),
        .full    (full)
    );

    lnc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_step  (q_step),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .beat    (frame_beat)
    );

endmodule

[rtl/core/lnc_checker.sv]
// Port-level checker of the node settings download sequencer and its bind statement.
`timescale 1ns / 1ps

module lnc_checker
    import lnc_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  full,
    input logic  pop,
    input logic  empty,
    input beat_t frame_beat
);

    logic expect_hdr_reg;

    // The next beat taken opens a frame after reset or after a checksum beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            expect_hdr_reg <= 1'b1;
        end else if (pop && !empty) begin
            expect_hdr_reg <= frame_beat.frame_end;
        end
    end

    a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("output or queue not idle right after reset");

    a_frame_opens_with_header: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && expect_hdr_reg |-> frame_beat.tx_byte == HDR_BYTE)
        else $error("frame does not start with the header byte");

    a_frame_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !frame_beat.frame_end |=> !empty)
        else $error("gap inside a frame");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(frame_beat))
        else $error("stalled beat changed");

endmodule

bind light_node_config_download_sequencer lnc_checker u_lnc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .frame_beat (frame_beat)
);
